[rtl/swk_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swk_pkg
// Shared types, constants and the CORDIC arctangent table for the swerve
// wheel kinematics block.
// ---------------------------------------------------------------------------
package swk_pkg;

  localparam int NUM_LANES   = 4;
  localparam int CORDIC_W    = 40;   // Q.20 scaled vector components
  localparam int NUM_STEPS   = 28;   // CORDIC steps, one per stage
  localparam int SQRT_STEPS  = 17;   // one root bit per stage
  localparam int REM_W       = 21;
  localparam int SQ_W        = 34;
  // input register, product, vectors, prep, steps, three post stages
  localparam int PIPE_LAT    = 4 + NUM_STEPS + 3;

  localparam logic signed [15:0] K_Q15      = 16'sd23170;
  localparam logic [12:0]        ZERO_FL_RST = 13'd3000;
  localparam logic [12:0]        ZERO_FR_RST = 13'd776;
  localparam logic [12:0]        ZERO_BL_RST = 13'd4865;
  localparam logic [12:0]        ZERO_BR_RST = 13'd4642;
  localparam logic [12:0]        WRAP_CNT    = 13'd8191;
  localparam logic [12:0]        HALF_CNT    = 13'd4096;

  typedef logic signed [16:0] comp_t;

  typedef enum logic [2:0] {
    REG_ZERO_FL = 3'd0,
    REG_ZERO_FR = 3'd1,
    REG_ZERO_BL = 3'd2,
    REG_ZERO_BR = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        vld;
    comp_t       a;
    comp_t       b;
    logic [12:0] meas;
  } lane_in_t;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/swk_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swk_front
// Registers the chassis command, scales the yaw rate by cos 45 degrees and
// forms the four module vectors.
// ---------------------------------------------------------------------------
module swk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic signed [15:0]  vel_x_i,
  input  logic signed [15:0]  vel_y_i,
  input  logic signed [15:0]  yaw_rate_i,
  input  logic [12:0]         meas_i [swk_pkg::NUM_LANES],
  output swk_pkg::lane_in_t   lanes_o [swk_pkg::NUM_LANES]
);

  logic                 v0_q, v1_q;
  logic signed [15:0]   vx0_q, vy0_q, wz0_q, vx1_q, vy1_q;
  logic [12:0]          meas0_q [swk_pkg::NUM_LANES];
  logic [12:0]          meas1_q [swk_pkg::NUM_LANES];
  logic signed [31:0]   prod_d, prod1_q;
  logic signed [31:0]   kw_sum;
  swk_pkg::comp_t       kw, vx_e, vy_e;
  swk_pkg::lane_in_t    lanes_d [swk_pkg::NUM_LANES];
  swk_pkg::lane_in_t    lanes_q [swk_pkg::NUM_LANES];

  assign prod_d = wz0_q * swk_pkg::K_Q15;
  assign kw_sum = prod1_q + 32'sd16384;
  assign kw     = kw_sum[31:15];
  assign vx_e   = {vx1_q[15], vx1_q};
  assign vy_e   = {vy1_q[15], vy1_q};

  always_comb begin
    // front left, front right, back left, back right
    lanes_d[0] = '{vld: v1_q, a: vx_e - kw, b: vy_e - kw, meas: meas1_q[0]};
    lanes_d[1] = '{vld: v1_q, a: vx_e - kw, b: vy_e + kw, meas: meas1_q[1]};
    lanes_d[2] = '{vld: v1_q, a: vx_e + kw, b: vy_e - kw, meas: meas1_q[2]};
    lanes_d[3] = '{vld: v1_q, a: vx_e + kw, b: vy_e + kw, meas: meas1_q[3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int i = 0; i < swk_pkg::NUM_LANES; i++) lanes_q[i] <= '0;
    end else begin
      v0_q <= take_i;
      v1_q <= v0_q;
      for (int i = 0; i < swk_pkg::NUM_LANES; i++) lanes_q[i] <= lanes_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    vx0_q   <= vel_x_i;
    vy0_q   <= vel_y_i;
    wz0_q   <= yaw_rate_i;
    vx1_q   <= vx0_q;
    vy1_q   <= vy0_q;
    prod1_q <= prod_d;
    for (int i = 0; i < swk_pkg::NUM_LANES; i++) begin
      meas0_q[i] <= meas_i[i];
      meas1_q[i] <= meas0_q[i];
    end
  end

  assign lanes_o = lanes_q;

endmodule

[rtl/swk_lane.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swk_lane
// One swerve module: pipelined CORDIC angle and digit-by-digit square root
// side by side, then count rounding, target wrap and error fold.
// ---------------------------------------------------------------------------
module swk_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swk_pkg::lane_in_t  in_i,
  input  logic [12:0]        zero_i,
  output logic               valid_o,
  output logic [16:0]        speed_o,
  output logic [12:0]        target_o,
  output logic [13:0]        err_o
);

  localparam int CW = swk_pkg::CORDIC_W;
  localparam int NS = swk_pkg::NUM_STEPS;
  localparam int RW = swk_pkg::REM_W;
  localparam int QW = swk_pkg::SQ_W;

  // prep stage
  logic                 vp_q, bnegp_q, zfp_q;
  logic signed [CW-1:0] xp_q, yp_q, xa, ya;
  logic [31:0]          accp_q;
  logic [31:0]          sqa_q, sqb_q;
  logic signed [33:0]   sqa_full, sqb_full;
  logic [12:0]          measp_q;

  assign xa       = {{3{in_i.a[16]}}, in_i.a, 20'd0};
  assign ya       = {{3{in_i.b[16]}}, in_i.b, 20'd0};
  assign sqa_full = in_i.a * in_i.a;
  assign sqb_full = in_i.b * in_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    // left half-plane: negate and start at half a turn
    xp_q    <= in_i.a[16] ? -xa : xa;
    yp_q    <= in_i.a[16] ? -ya : ya;
    accp_q  <= in_i.a[16] ? 32'h8000_0000 : 32'd0;
    sqa_q   <= sqa_full[31:0];
    sqb_q   <= sqb_full[31:0];
    bnegp_q <= in_i.b[16];
    zfp_q   <= (in_i.a == '0) && (in_i.b == '0);
    measp_q <= in_i.meas;
  end

  // step stages
  logic                 v_q    [NS];
  logic signed [CW-1:0] x_q    [NS];
  logic signed [CW-1:0] y_q    [NS];
  logic [31:0]          acc_q  [NS];
  logic [QW-1:0]        sq_q   [NS];
  logic [RW-1:0]        rem_q  [NS];
  logic [16:0]          root_q [NS];
  logic                 bneg_q [NS];
  logic                 zf_q   [NS];
  logic [12:0]          meas_q [NS];

  for (genvar gj = 0; gj < NS; gj++) begin : g_step
    logic                 vi, bi, zi;
    logic signed [CW-1:0] xi, yi, dx, dy, x_d, y_d;
    logic [31:0]          acci, acc_d;
    logic [QW-1:0]        sqi, sq_d;
    logic [RW-1:0]        remi, rem_d, r2, trial;
    logic [16:0]          rooti, root_d;
    logic [12:0]          mi;

    if (gj == 0) begin : g_first
      assign vi    = vp_q;
      assign xi    = xp_q;
      assign yi    = yp_q;
      assign acci  = accp_q;
      assign sqi   = {2'b00, sqa_q} + {2'b00, sqb_q};
      assign remi  = '0;
      assign rooti = '0;
      assign bi    = bnegp_q;
      assign zi    = zfp_q;
      assign mi    = measp_q;
    end else begin : g_next
      assign vi    = v_q[gj-1];
      assign xi    = x_q[gj-1];
      assign yi    = y_q[gj-1];
      assign acci  = acc_q[gj-1];
      assign sqi   = sq_q[gj-1];
      assign remi  = rem_q[gj-1];
      assign rooti = root_q[gj-1];
      assign bi    = bneg_q[gj-1];
      assign zi    = zf_q[gj-1];
      assign mi    = meas_q[gj-1];
    end

    assign dx = yi >>> gj;
    assign dy = xi >>> gj;

    always_comb begin
      // rotate clockwise while y is non-negative
      if (!yi[CW-1]) begin
        x_d   = xi + dx;
        y_d   = yi - dy;
        acc_d = acci + swk_pkg::atan_turn(5'(gj));
      end else begin
        x_d   = xi - dx;
        y_d   = yi + dy;
        acc_d = acci - swk_pkg::atan_turn(5'(gj));
      end
    end

    if (gj >= 1 && gj <= swk_pkg::SQRT_STEPS) begin : g_sqrt
      assign r2    = {remi[RW-3:0], sqi[QW-1-2*(gj-1) -: 2]};
      assign trial = {2'b00, rooti, 2'b01};
      always_comb begin
        if (r2 >= trial) begin
          rem_d  = r2 - trial;
          root_d = {rooti[15:0], 1'b1};
        end else begin
          rem_d  = r2;
          root_d = {rooti[15:0], 1'b0};
        end
      end
    end else begin : g_hold
      assign r2     = remi;
      assign trial  = '0;
      assign rem_d  = r2 | trial;
      assign root_d = rooti;
    end

    assign sq_d = sqi;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gj] <= 1'b0;
      end else begin
        v_q[gj] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[gj]    <= x_d;
      y_q[gj]    <= y_d;
      acc_q[gj]  <= acc_d;
      sq_q[gj]   <= sq_d;
      rem_q[gj]  <= rem_d;
      root_q[gj] <= root_d;
      bneg_q[gj] <= bi;
      zf_q[gj]   <= zi;
      meas_q[gj] <= mi;
    end
  end

  // post stage A: angle count and rounded speed
  logic [31:0]        acc_r;
  logic [12:0]        raw;
  logic signed [13:0] cnt_d, cnt_q;
  logic [16:0]        spd_d, spd_a_q, spd_b_q;
  logic               va_q, vb_q;
  logic [12:0]        meas_a_q, meas_b_q;

  assign acc_r = acc_q[NS-1] + 32'h0004_0000;
  assign raw   = acc_r[31:19];

  always_comb begin
    if (zf_q[NS-1]) begin
      cnt_d = '0;
    end else if (raw == swk_pkg::HALF_CNT && bneg_q[NS-1]) begin
      cnt_d = -14'sd4096;
    end else if (raw > swk_pkg::HALF_CNT) begin
      cnt_d = $signed({1'b0, raw}) - 14'sd8192;
    end else begin
      cnt_d = $signed({1'b0, raw});
    end
    spd_d = root_q[NS-1] +
            17'(rem_q[NS-1][18:0] > {2'b00, root_q[NS-1]});
  end

  // post stage B: wrap the target
  logic signed [14:0] sum;
  logic [12:0]        tgt_d, tgt_q;

  assign sum = $signed({2'b00, zero_i}) + $signed({cnt_q[13], cnt_q});

  always_comb begin
    if (!cnt_q[13] && cnt_q != '0) begin
      tgt_d = (sum > $signed({2'b00, swk_pkg::WRAP_CNT})) ?
              13'(sum - $signed({2'b00, swk_pkg::WRAP_CNT})) : sum[12:0];
    end else if (cnt_q[13]) begin
      tgt_d = sum[14] ? 13'(sum + $signed({2'b00, swk_pkg::WRAP_CNT})) : sum[12:0];
    end else begin
      tgt_d = zero_i;
    end
  end

  // post stage C: fold the error onto the shortest path
  logic signed [14:0] e_raw;
  logic [13:0]        err_d, err_q;
  logic [16:0]        spd_c_q;
  logic [12:0]        tgt_c_q;
  logic               vc_q;

  assign e_raw = $signed({2'b00, tgt_q}) - $signed({2'b00, meas_b_q});

  always_comb begin
    if (e_raw > $signed({2'b00, swk_pkg::HALF_CNT})) begin
      err_d = 14'(e_raw - $signed({2'b00, swk_pkg::WRAP_CNT}));
    end else if (e_raw < -$signed({2'b00, swk_pkg::HALF_CNT})) begin
      err_d = 14'(e_raw + $signed({2'b00, swk_pkg::WRAP_CNT}));
    end else begin
      err_d = e_raw[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= v_q[NS-1];
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    spd_a_q  <= spd_d;
    meas_a_q <= meas_q[NS-1];
    tgt_q    <= tgt_d;
    spd_b_q  <= spd_a_q;
    meas_b_q <= meas_a_q;
    err_q    <= err_d;
    tgt_c_q  <= tgt_q;
    spd_c_q  <= spd_b_q;
  end

  assign valid_o  = vc_q;
  assign speed_o  = spd_c_q;
  assign target_o = tgt_c_q;
  assign err_o    = err_q;

endmodule

[rtl/swerve_wheel_kinematics_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swerve_wheel_kinematics_top
// Four-wheel swerve inverse kinematics: wheel speed, wrapped steering target
// and shortest-path steering error for every module.
// ---------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  command   | start, busy            | vel_x_i, vel_y_i, yaw_rate_i, meas_*_i
//  result    | valid_o (one cycle)    | speed_*_o, target_*_o, err_*_o
//  config    | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A new word can enter every cycle; busy stays low. Each result word passes
//  the input register, product, vectors and prep stages, the 28-stage CORDIC
//  that each module owns and the post stages before it is on the ports.
//  Reset clears the valid bits and loads the default zero offsets.
//  The result side has no backpressure, so the pipeline never holds.
// ---------------------------------------------------------------------------
module swerve_wheel_kinematics_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] yaw_rate_i,
  input  logic [12:0]        meas_front_left_i,
  input  logic [12:0]        meas_front_right_i,
  input  logic [12:0]        meas_back_left_i,
  input  logic [12:0]        meas_back_right_i,
  output logic               valid_o,
  output logic [16:0]        speed_front_left_o,
  output logic [16:0]        speed_front_right_o,
  output logic [16:0]        speed_back_left_o,
  output logic [16:0]        speed_back_right_o,
  output logic [12:0]        target_front_left_o,
  output logic [12:0]        target_front_right_o,
  output logic [12:0]        target_back_left_o,
  output logic [12:0]        target_back_right_o,
  output logic signed [13:0] err_front_left_o,
  output logic signed [13:0] err_front_right_o,
  output logic signed [13:0] err_back_left_o,
  output logic signed [13:0] err_back_right_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i
);

  logic [12:0]       zero_q [swk_pkg::NUM_LANES];
  logic [12:0]       meas   [swk_pkg::NUM_LANES];
  swk_pkg::lane_in_t lanes  [swk_pkg::NUM_LANES];
  logic [swk_pkg::NUM_LANES-1:0] lane_vld;
  logic [16:0]       spd    [swk_pkg::NUM_LANES];
  logic [12:0]       tgt    [swk_pkg::NUM_LANES];
  logic [13:0]       err    [swk_pkg::NUM_LANES];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q[0] <= swk_pkg::ZERO_FL_RST;
      zero_q[1] <= swk_pkg::ZERO_FR_RST;
      zero_q[2] <= swk_pkg::ZERO_BL_RST;
      zero_q[3] <= swk_pkg::ZERO_BR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // drop writes to unknown indexes
      case (swk_pkg::cfg_reg_e'(cfg_index_i))
        swk_pkg::REG_ZERO_FL: zero_q[0] <= cfg_data_i;
        swk_pkg::REG_ZERO_FR: zero_q[1] <= cfg_data_i;
        swk_pkg::REG_ZERO_BL: zero_q[2] <= cfg_data_i;
        swk_pkg::REG_ZERO_BR: zero_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign meas[0] = meas_front_left_i;
  assign meas[1] = meas_front_right_i;
  assign meas[2] = meas_back_left_i;
  assign meas[3] = meas_back_right_i;

  swk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (start && !busy),
    .vel_x_i    (vel_x_i),
    .vel_y_i    (vel_y_i),
    .yaw_rate_i (yaw_rate_i),
    .meas_i     (meas),
    .lanes_o    (lanes)
  );

  for (genvar gl = 0; gl < swk_pkg::NUM_LANES; gl++) begin : g_lane
    swk_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .in_i     (lanes[gl]),
      .zero_i   (zero_q[gl]),
      .valid_o  (lane_vld[gl]),
      .speed_o  (spd[gl]),
      .target_o (tgt[gl]),
      .err_o    (err[gl])
    );
  end

  assign valid_o              = &lane_vld;
  assign speed_front_left_o   = spd[0];
  assign speed_front_right_o  = spd[1];
  assign speed_back_left_o    = spd[2];
  assign speed_back_right_o   = spd[3];
  assign target_front_left_o  = tgt[0];
  assign target_front_right_o = tgt[1];
  assign target_back_left_o   = tgt[2];
  assign target_back_right_o  = tgt[3];
  assign err_front_left_o     = err[0];
  assign err_front_right_o    = err[1];
  assign err_back_left_o      = err[2];
  assign err_back_right_o     = err[3];

endmodule

[rtl/swk_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swk_checker
// Port-level checks on latency, result ranges and the always-open channels.
// ---------------------------------------------------------------------------
module swk_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               valid_o,
  input logic               cfg_ready_o,
  input logic signed [13:0] err_front_left_o,
  input logic signed [13:0] err_back_right_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(swk_pkg::PIPE_LAT) valid_o)
    else $error("result word missing after command");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("command or config channel closed");

  a_err_fl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (err_front_left_o >= -14'sd4096 && err_front_left_o <= 14'sd4096))
    else $error("front left error out of range");

  a_err_br: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (err_back_right_o >= -14'sd4096 && err_back_right_o <= 14'sd4096))
    else $error("back right error out of range");

endmodule

bind swerve_wheel_kinematics_top swk_checker u_swk_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .valid_o          (valid_o),
  .cfg_ready_o      (cfg_ready_o),
  .err_front_left_o (err_front_left_o),
  .err_back_right_o (err_back_right_o)
);
